// ===== hw/rtl/b64c_pkg.sv =====
// Shared types, constants and alphabet functions for the LSB-first base64 codec.
// Depends on nothing; every other file of the codec but b64c_chan_if imports it.
package b64c_pkg;

    // Width of the bit accumulator and of its fill count.
    localparam int ACC_W = 14;
    localparam int CNT_W = 4;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Characters with a special place in the alphabet.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // Symbol value returned for a character outside the alphabet.
    localparam logic [6:0] SYM_BAD = 7'd64;

    // One input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } result_t;

    // Work handed from the front to the back: up to three raw values.
    // In encode mode each value holds a 6-bit symbol index.
    typedef struct packed {
        logic            encode;
        logic [1:0]      count;
        logic            last;
        logic            bad;
        logic [2:0][7:0] vals;
    } job_t;

    // Map a character to its symbol value, or SYM_BAD when it is not in the set.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [6:0] v;
        v = SYM_BAD;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = 7'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = 7'(c - CH_LOWER_A + 8'd26);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = 7'(c - CH_DIGIT_0 + 8'd52);
        end else if (c == CH_PLUS) begin
            v = 7'd62;
        end else if (c == CH_MINUS) begin
            v = 7'd63;
        end
        return v;
    endfunction

    // Map a 6-bit symbol value to its alphabet character.
    function automatic logic [7:0] sym_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = CH_UPPER_A + {2'd0, s};
        end else if (s < 6'd52) begin
            c = CH_LOWER_A + {2'd0, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = CH_DIGIT_0 + {2'd0, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = CH_PLUS;
        end else begin
            c = CH_MINUS;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64c_chan_if.sv =====
// Valid/ready channel interface used for requests, results and configuration.
// Depends on nothing; the payload type is a parameter.
interface b64c_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/b64c_front.sv =====
// Front of the codec: accepts requests, holds the bit accumulator and the
// direction register, and turns each request that yields results into a job. Uses b64c_pkg.
module b64c_front (
    input  logic            clk,
    input  logic            rst_n,
    b64c_chan_if.sink       items,
    b64c_chan_if.sink       cfg,
    output logic            job_valid,
    input  logic            job_ready,
    output b64c_pkg::job_t  job
);
    import b64c_pkg::*;

    logic             dir_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             item_fire;
    logic             cfg_fire;
    logic             in_last;
    logic [7:0]       in_byte;

    // Encode path signals.
    logic [2:0]       enc_shift;
    logic [ACC_W-1:0] enc_word;
    logic [3:0]       enc_total;
    logic             enc_two;
    logic [3:0]       enc_rem;
    logic [17:0]      enc_ext;
    logic [ACC_W-1:0] enc_rest;
    logic             enc_flush;

    // Decode path signals.
    logic [6:0]       dec_val;
    logic             dec_bad;
    logic [2:0]       dec_shift;
    logic [ACC_W-1:0] dec_word;
    logic [3:0]       dec_total;
    logic             dec_one;
    logic [3:0]       dec_rem;
    logic [ACC_W-1:0] dec_rest;
    logic [7:0]       dec_mask;
    logic [7:0]       dec_tail;
    logic             dec_flush;

    assign in_byte   = items.data.in_byte;
    assign in_last   = items.data.in_last;
    assign items.ready = job_ready;
    assign cfg.ready   = 1'b1;
    assign item_fire = items.valid && job_ready;
    assign cfg_fire  = cfg.valid;

    // Encode: append eight bits, then cut off one or two full symbols.
    always_comb
    begin
        enc_shift = (cnt_reg > 4'd5) ? 3'd5 : cnt_reg[2:0];
        enc_word  = acc_reg | 14'({6'd0, in_byte} << enc_shift);
        enc_total = {1'b0, enc_shift} + 4'd8;
        enc_two   = (enc_total >= 4'd12);
        enc_rem   = enc_two ? (enc_total - 4'd12) : (enc_total - 4'd6);
        enc_ext   = {4'd0, enc_word};
        enc_rest  = enc_two ? (enc_word >> 12) : (enc_word >> 6);
        enc_flush = in_last && (enc_rem != 4'd0);
    end

    // Decode: append six bits, then cut off at most one full byte.
    always_comb
    begin
        dec_val   = char_value(in_byte);
        dec_bad   = dec_val[6];
        dec_shift = (cnt_reg > 4'd7) ? 3'd7 : cnt_reg[2:0];
        dec_word  = acc_reg | 14'({8'd0, dec_val[5:0]} << dec_shift);
        dec_total = {1'b0, dec_shift} + 4'd6;
        dec_one   = (dec_total >= 4'd8);
        dec_rem   = dec_one ? (dec_total - 4'd8) : dec_total;
        dec_rest  = dec_one ? (dec_word >> 8) : dec_word;
        dec_mask  = ~(8'hFF << dec_rem[2:0]);
        dec_tail  = dec_rest[7:0] & dec_mask;
        dec_flush = in_last && (dec_rem != 4'd0);
    end

    // Build the job and the next accumulator state.
    always_comb
    begin
        job.encode = (dir_reg == DIR_ENCODE);
        job.last   = in_last;
        job.bad    = 1'b0;
        job.vals   = '0;
        job.count  = 2'd0;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        if (dir_reg == DIR_ENCODE) begin
            job.vals[0] = {2'd0, enc_ext[5:0]};
            job.vals[1] = {2'd0, enc_ext[11:6]};
            job.vals[2] = {2'd0, enc_ext[17:12]};
            job.count   = enc_two ? (enc_flush ? 2'd3 : 2'd2)
                                  : (enc_flush ? 2'd2 : 2'd1);
            acc_next    = enc_rest;
            cnt_next    = enc_rem;
        end else if (dec_bad) begin
            job.bad   = 1'b1;
            job.count = 2'd1;
            acc_next  = '0;
            cnt_next  = '0;
        end else begin
            if (dec_one) begin
                job.vals[0] = dec_word[7:0];
                job.vals[1] = dec_tail;
            end else begin
                job.vals[0] = dec_tail;
            end
            job.count = {1'b0, dec_one} + {1'b0, dec_flush};
            acc_next  = dec_rest;
            cnt_next  = dec_rem;
        end
        if (in_last) begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    // Requests that produce no result are absorbed without a job.
    assign job_valid = items.valid && (job.count != 2'd0);

    // Direction register and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dir_reg <= DIR_ENCODE;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (cfg_fire) begin
            dir_reg <= cfg.data;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (item_fire) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/b64c_queue.sv =====
// Short job queue that lets the front and the back stall independently.
// Uses b64c_pkg for the job type.
module b64c_queue #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  b64c_pkg::job_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output b64c_pkg::job_t  pop_data
);
    import b64c_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    job_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop_fire && !push_fire) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/b64c_back.sv =====
// Back of the codec: takes jobs from the queue and sends their results one
// per cycle, while the result side takes them, through an output register. Uses b64c_pkg.
module b64c_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  b64c_pkg::job_t  job,
    b64c_chan_if.source     results
);
    import b64c_pkg::*;

    job_t    cur_reg;
    logic    cur_valid_reg;
    logic [1:0] idx_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    slot_free;
    logic    emit;
    logic    is_final;
    logic    cur_done;
    logic    take_job;
    logic [7:0] cur_val;
    result_t res;

    assign slot_free = !out_valid_reg || results.ready;
    assign emit      = cur_valid_reg && slot_free;
    assign is_final  = (idx_reg == cur_reg.count - 2'd1);
    assign cur_done  = emit && is_final;
    assign job_ready = !cur_valid_reg || cur_done;
    assign take_job  = job_valid && job_ready;

    // Select the raw value of the current result.
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur_val = cur_reg.vals[0];
            2'd1:    cur_val = cur_reg.vals[1];
            2'd2:    cur_val = cur_reg.vals[2];
            default: cur_val = 8'd0;
        endcase
    end

    // Form the result, mapping symbols to characters when encoding.
    always_comb
    begin
        res.out_byte = cur_reg.encode ? sym_char(cur_val[5:0]) : cur_val;
        res.out_last = cur_reg.last && is_final;
        res.bad_char = cur_reg.bad;
    end

    // Current job and result index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (take_job) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (cur_done) begin
            cur_valid_reg <= 1'b0;
        end else if (emit) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job) begin
            cur_reg <= job;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (results.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_reg <= res;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule

// ===== hw/rtl/base64_lsb_first_codec.sv =====
// Top level of the LSB-first, unpadded base64 codec: front, job queue, back.
// Depends on b64c_pkg, b64c_chan_if, b64c_front, b64c_queue and b64c_back.
//
//   Channel   Direction  Payload                          Request taken when
//   items     in         in_byte[7:0], in_last            items.valid && items.ready
//   results   out        out_byte[7:0], out_last, bad_char results.valid && results.ready
//   cfg       in         direction (1 bit)                cfg.valid && cfg.ready
//
// A request is taken whenever the job queue has room; it yields zero to three
// results, sent at one per cycle, while the result side takes them, from a single
// output register. Encoding is bound by that result rate: three bytes yield four
// symbols in a long message; decoding keeps up with a request every cycle while
// the result side takes every result.
// Reset clears the accumulator and selects encoding; there is no clearing pass.
// The output register and the queue let either side stall without losing data.
module base64_lsb_first_codec #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    b64c_chan_if.sink   items,
    b64c_chan_if.source results,
    b64c_chan_if.sink   cfg
);
    import b64c_pkg::*;

    logic f_job_valid;
    logic f_job_ready;
    job_t f_job;
    logic q_pop_valid;
    logic q_pop_ready;
    job_t q_pop_job;

    // Front: accepts requests and builds jobs.
    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .job_valid (f_job_valid),
        .job_ready (f_job_ready),
        .job       (f_job)
    );

    // Queue between front and back.
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_job_valid),
        .push_ready (f_job_ready),
        .push_data  (f_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_job)
    );

    // Back: sends the results of each job.
    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_pop_valid),
        .job_ready (q_pop_ready),
        .job       (q_pop_job),
        .results   (results)
    );

    // An error result never carries a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.bad_char |-> results.data.out_byte == 8'd0)
        else $error("error result with nonzero byte");

    // Every job in the queue produces at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop_valid |-> q_pop_job.count != 2'd0)
        else $error("empty job reached the back");

    // An error job holds exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop_valid && q_pop_job.bad |-> q_pop_job.count == 2'd1)
        else $error("error job with more than one result");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the LSB-first, unpadded base64 codec.
// Depends on b64c_pkg, b64c_chan_if and base64_lsb_first_codec, and through it on the codec's other files.
// Directed table first, then random messages in both directions, checked against a predictor.
module tb_top;
    import b64c_pkg::*;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-";
    localparam int unsigned ACC_MASK = (1 << ACC_W) - 1;
    localparam int unsigned NOT_IN_SET = 64;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 48;

    // One row of the directed table: a request or a direction write.
    typedef enum logic {ROW_ITEM, ROW_DIR} row_kind_t;
    typedef struct packed {
        row_kind_t  kind;
        logic       dir;
        logic [7:0] in_byte;
        logic       in_last;
        logic [1:0] typed_n;
        result_t    typed_a;
        result_t    typed_b;
    } row_t;

    localparam result_t NO_RES = '0;
    localparam row_t DIRECTED_ROWS [25] = '{
        // Encoding right after reset: extremes of the byte with a flush.
        '{ROW_ITEM, DIR_ENCODE, 8'h00, 1'b1, 2'd2, '{"A", 1'b0, 1'b0}, '{"A", 1'b1, 1'b0}},
        '{ROW_ITEM, DIR_ENCODE, 8'hFF, 1'b1, 2'd2, '{"-", 1'b0, 1'b0}, '{"D", 1'b1, 1'b0}},
        '{ROW_ITEM, DIR_ENCODE, 8'hFF, 1'b0, 2'd1, '{"-", 1'b0, 1'b0}, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'hFF, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'h80, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'h5A, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'h7F, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'h01, 1'b1, 2'd0, NO_RES, NO_RES},
        '{ROW_DIR,  DIR_DECODE, 8'h00, 1'b0, 2'd0, NO_RES, NO_RES},
        // Decoding: range ends of the alphabet, then a partial byte on the last one.
        '{ROW_ITEM, DIR_DECODE, "A",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "z",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "0",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "9",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "+",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "-",   1'b1, 2'd0, NO_RES, NO_RES},
        // Characters outside the alphabet, with and without the last mark.
        '{ROW_ITEM, DIR_DECODE, "*",   1'b0, 2'd1, '{8'd0, 1'b0, 1'b1}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, 8'hFF, 1'b1, 2'd1, '{8'd0, 1'b1, 1'b1}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, 8'h00, 1'b0, 2'd1, '{8'd0, 1'b0, 1'b1}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "Z",   1'b1, 2'd1, '{8'd25, 1'b1, 1'b0}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "@",   1'b1, 2'd1, '{8'd0, 1'b1, 1'b1}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "{",   1'b0, 2'd1, '{8'd0, 1'b0, 1'b1}, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "-",   1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_DECODE, "-",   1'b0, 2'd0, NO_RES, NO_RES},
        // Switching back drops the partly collected bits.
        '{ROW_DIR,  DIR_ENCODE, 8'h00, 1'b0, 2'd0, NO_RES, NO_RES},
        '{ROW_ITEM, DIR_ENCODE, 8'hA5, 1'b1, 2'd0, NO_RES, NO_RES}
    };

    logic clk;
    logic rst_n;

    b64c_chan_if #(.payload_t(item_t))   items_if ();
    b64c_chan_if #(.payload_t(result_t)) results_if ();
    b64c_chan_if #(.payload_t(logic))    cfg_if ();

    base64_lsb_first_codec dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Predictor state: direction and the bits collected so far.
    logic             dir_mode;
    logic [ACC_W-1:0] acc_bits;
    int unsigned      acc_count;

    // Results that the codec still owes, oldest first.
    result_t pending_out [$];
    int      fail_count;
    bit      steady_phase;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Symbol value of a character, or NOT_IN_SET.
    function automatic int unsigned symbol_of(input logic [7:0] ch);
        for (int i = 0; i < 64; i++) begin
            if (ALPHABET[i] == ch) begin
                return i;
            end
        end
        return NOT_IN_SET;
    endfunction

    // Work out the results of one request and advance the predictor state.
    function automatic void code_item(input item_t it, output result_t res [3], output int n);
        int unsigned a;
        int unsigned c;
        int unsigned v;
        n = 0;
        a = acc_bits;
        c = acc_count;
        foreach (res[i]) begin
            res[i] = '0;
        end
        if (dir_mode == DIR_ENCODE) begin
            if (c > 5) begin
                c = 5;
            end
            a = (a | (32'(it.in_byte) << c)) & ACC_MASK;
            c += 8;
            while (c >= 6) begin
                res[n] = '{ALPHABET[a & 63], 1'b0, 1'b0};
                n++;
                a >>= 6;
                c -= 6;
            end
            if (it.in_last && c > 0) begin
                res[n] = '{ALPHABET[a & 63], 1'b0, 1'b0};
                n++;
            end
        end else begin
            v = symbol_of(it.in_byte);
            // A character outside the alphabet gives one error result and clears the bits.
            if (v == NOT_IN_SET) begin
                res[0] = '{8'd0, it.in_last, 1'b1};
                n = 1;
                acc_bits = '0;
                acc_count = 0;
                return;
            end
            if (c > 7) begin
                c = 7;
            end
            a = (a | (v << c)) & ACC_MASK;
            c += 6;
            while (c >= 8) begin
                res[n] = '{8'(a), 1'b0, 1'b0};
                n++;
                a >>= 8;
                c -= 8;
            end
            if (it.in_last && c > 0) begin
                res[n] = '{8'(a & ((1 << c) - 1)), 1'b0, 1'b0};
                n++;
            end
        end
        // End of message: mark the final result and start over.
        if (it.in_last) begin
            if (n > 0) begin
                res[n-1].out_last = 1'b1;
            end
            a = 0;
            c = 0;
        end
        acc_bits = a[ACC_W-1:0];
        acc_count = c;
    endfunction

    // Idle length: mostly none or short, a few long, none at all in a steady phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Send one request; on acceptance queue the expected results.
    task automatic drive_request(input item_t it, input logic [1:0] typed_n,
                                 input result_t typed_a, input result_t typed_b);
        int gap;
        int n;
        result_t res [3];
        gap = pick_gap();
        if (gap > 0) begin
            items_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_if.valid = 1'b1;
        items_if.data = it;
        do @(posedge clk); while (!items_if.ready);
        code_item(it, res, n);
        if (typed_n == 2'd0) begin
            for (int i = 0; i < n; i++) begin
                pending_out.push_back(res[i]);
            end
        end else begin
            pending_out.push_back(typed_a);
            if (typed_n == 2'd2) begin
                pending_out.push_back(typed_b);
            end
        end
        @(negedge clk);
    endtask

    // Wait until every result is in and the codec has settled.
    task automatic drain();
        items_if.valid = 1'b0;
        while (pending_out.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write the direction register while the codec is idle.
    task automatic write_direction(input logic d);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.data = d;
        do @(posedge clk); while (!cfg_if.ready);
        dir_mode = d;
        acc_bits = '0;
        acc_count = 0;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Result side: random stalls, driven at the falling edge.
    initial begin
        int stall;
        stall = 0;
        results_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                results_if.ready = 1'b0;
                stall--;
            end else begin
                results_if.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && results_if.valid && results_if.ready) begin
            got = results_if.data;
            if (pending_out.size() == 0) begin
                $display("%0t: result with nothing expected: byte %h last %b bad %b",
                         $time, got.out_byte, got.out_last, got.bad_char);
                fail_count++;
            end else begin
                want = pending_out.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, got.out_byte);
                    fail_count++;
                end
                if (got.out_last !== want.out_last) begin
                    $display("%0t: out_last expected %b actual %b",
                             $time, want.out_last, got.out_last);
                    fail_count++;
                end
                if (got.bad_char !== want.bad_char) begin
                    $display("%0t: bad_char expected %b actual %b",
                             $time, want.bad_char, got.bad_char);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random messages in phases.
    initial begin
        item_t it;
        int left;
        int len;
        rst_n = 1'b0;
        items_if.valid = 1'b0;
        items_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = 1'b0;
        fail_count = 0;
        steady_phase = 1'b0;
        dir_mode = DIR_ENCODE;
        acc_bits = '0;
        acc_count = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_DIR) begin
                write_direction(DIRECTED_ROWS[r].dir);
            end else begin
                it.in_byte = DIRECTED_ROWS[r].in_byte;
                it.in_last = DIRECTED_ROWS[r].in_last;
                drive_request(it, DIRECTED_ROWS[r].typed_n,
                              DIRECTED_ROWS[r].typed_a, DIRECTED_ROWS[r].typed_b);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            steady_phase = (p % 4 == 3);
            if (p % 3 == 0) begin
                write_direction(logic'($urandom_range(0, 1)));
            end else begin
                write_direction((p % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            end
            // Messages of random length; the one open at the end of a phase is cut off.
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len && left > 0; k++) begin
                    if (dir_mode == DIR_ENCODE || $urandom_range(0, 9) == 0) begin
                        it.in_byte = 8'($urandom_range(0, 255));
                    end else begin
                        it.in_byte = ALPHABET[$urandom_range(0, 63)];
                    end
                    it.in_last = (k == len - 1);
                    drive_request(it, 2'd0, NO_RES, NO_RES);
                    left--;
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("base64_lsb_first_codec test passed");
        end else begin
            $display("base64_lsb_first_codec test failed");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin
        #5000000;
        $display("base64_lsb_first_codec test failed");
        $finish;
    end

endmodule
